FILE: src/gtg_pkg.sv
package gtg_pkg;

  localparam int CordicStages = 16;
  localparam int CW = 28;
  localparam int ZW = 20;
  localparam int GuardBits = 8;
  localparam logic signed [ZW-1:0] HalfPiQ16 = 20'sd102944;
  localparam logic [15:0] InvGainQ16 = 16'd39797;
  localparam logic [14:0] OutMax = 15'd32767;

  typedef enum logic [2:0] {
    REG_TARGET_X  = 3'd0,
    REG_TARGET_Y  = 3'd1,
    REG_GAIN      = 3'd2,
    REG_MAX_SPEED = 3'd3,
    REG_DIST_THR  = 3'd4,
    REG_ANG_THR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] speed_gain;
    logic [14:0] max_speed;
    logic [14:0] distance_threshold;
    logic [14:0] angle_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [15:0]   head;
  } cstage_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    case (i)
      0: atan_q16 = 20'sd51472;
      1: atan_q16 = 20'sd30386;
      2: atan_q16 = 20'sd16055;
      3: atan_q16 = 20'sd8150;
      4: atan_q16 = 20'sd4091;
      5: atan_q16 = 20'sd2047;
      6: atan_q16 = 20'sd1024;
      7: atan_q16 = 20'sd512;
      8: atan_q16 = 20'sd256;
      9: atan_q16 = 20'sd128;
      10: atan_q16 = 20'sd64;
      11: atan_q16 = 20'sd32;
      12: atan_q16 = 20'sd16;
      13: atan_q16 = 20'sd8;
      14: atan_q16 = 20'sd4;
      15: atan_q16 = 20'sd2;
      16: atan_q16 = 20'sd1;
      default: atan_q16 = '0;
    endcase
  endfunction

endpackage

FILE: src/gtg_if.sv
interface gtg_pose_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_cmd_if;
  logic        valid;
  logic        ready;
  logic [14:0] linear_speed;
  logic [14:0] angular_speed;
  modport source (output valid, linear_speed, angular_speed, input ready);
  modport sink   (input valid, linear_speed, angular_speed, output ready);
endinterface

FILE: src/go_to_goal_heading_controller_core.sv
// Go-to-goal heading controller.
// Channel pose (sink): pos_x, pos_y (Q6.10) and heading (Q4.12) per item.
// Channel cmd (source): linear_speed (unsigned Q5.10) and angular_speed (unsigned Q3.12).
// Config port: cfg_we, cfg_index, cfg_data; index 0..5 selects target_x,
// target_y, speed_gain, max_speed, distance_threshold, angle_threshold.
// Write config only while the pipeline is empty.
// Pipeline: between the pose accept and the rise of cmd.valid, the item
// passes 21 registers: one offset stage, 16 CORDIC stages, three stages for
// scaling, error and selection, and the output register.
// Throughput: one item per cycle; the pipeline holds when cmd is stalled.
// The skid register on the output keeps pose.ready high in a stall until it holds
// an item, then the whole pipeline freezes; no item is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
module go_to_goal_heading_controller_core
  import gtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  gtg_pose_if.sink    pose,
  gtg_cmd_if.source   cmd
);

  logic signed [15:0] target_x, target_y;
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= 16'sd1024;
      target_y <= 16'sd1024;
      cfg.speed_gain <= 15'd4096;
      cfg.max_speed <= 15'd3072;
      cfg.distance_threshold <= 15'd102;
      cfg.angle_threshold <= 15'd819;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TARGET_X:  target_x <= cfg_data;
        REG_TARGET_Y:  target_y <= cfg_data;
        REG_GAIN:      cfg.speed_gain <= cfg_data[14:0];
        REG_MAX_SPEED: cfg.max_speed <= cfg_data[14:0];
        REG_DIST_THR:  cfg.distance_threshold <= cfg_data[14:0];
        REG_ANG_THR:   cfg.angle_threshold <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic pipe_valid;
  logic [14:0] pipe_lin, pipe_ang;
  logic skid_full;
  logic [14:0] skid_lin, skid_ang;
  logic en;

  assign en = !skid_full;
  assign pose.ready = en;

  cstage_t s0_next, s0;
  logic v0;
  logic signed [16:0] dx, dy;
  logic signed [CW-1:0] gx, gy;

  always_comb begin
    dx = 17'(target_x) - 17'(pose.pos_x);
    dy = 17'(target_y) - 17'(pose.pos_y);
    gx = CW'(dx) <<< GuardBits;
    gy = CW'(dy) <<< GuardBits;
    s0_next.head = pose.heading;
    s0_next.x = gx;
    s0_next.y = gy;
    s0_next.z = '0;
    if (gx[CW-1]) begin
      if (!gy[CW-1]) begin
        s0_next.x = gy;
        s0_next.y = -gx;
        s0_next.z = HalfPiQ16;
      end else begin
        s0_next.x = -gy;
        s0_next.y = gx;
        s0_next.z = -HalfPiQ16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= pose.valid;
    end
    if (en) begin
      s0 <= s0_next;
    end
  end

  cstage_t sd [CordicStages+1];
  logic sv [CordicStages+1];
  assign sd[0] = s0;
  assign sv[0] = v0;

  for (genvar g = 0; g < CordicStages; g++) begin : g_cordic
    gtg_cordic_stage u_stage (
      .clk(clk), .rst(rst), .en(en), .idx(5'(g)),
      .in_valid(sv[g]), .in_data(sd[g]),
      .out_valid(sv[g+1]), .out_data(sd[g+1])
    );
  end

  gtg_decide u_decide (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(sv[CordicStages]), .in_data(sd[CordicStages]),
    .out_valid(pipe_valid), .linear_speed(pipe_lin), .angular_speed(pipe_ang)
  );

  logic out_valid_r;
  logic [14:0] out_lin, out_ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (!out_valid_r || cmd.ready) begin
        if (skid_full) begin
          out_valid_r <= 1'b1;
          skid_full <= 1'b0;
        end else begin
          out_valid_r <= pipe_valid;
        end
      end else if (pipe_valid && !skid_full) begin
        skid_full <= 1'b1;
      end
    end
    if (!out_valid_r || cmd.ready) begin
      out_lin <= skid_full ? skid_lin : pipe_lin;
      out_ang <= skid_full ? skid_ang : pipe_ang;
    end else if (!skid_full) begin
      skid_lin <= pipe_lin;
      skid_ang <= pipe_ang;
    end
  end

  assign cmd.valid = out_valid_r;
  assign cmd.linear_speed = out_lin;
  assign cmd.angular_speed = out_ang;

endmodule

FILE: src/gtg_cordic_stage.sv
module gtg_cordic_stage
  import gtg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic [4:0] idx,
  input  logic    in_valid,
  input  cstage_t in_data,
  output logic    out_valid,
  output cstage_t out_data
);

  cstage_t nxt;
  logic signed [CW-1:0] xs, ys;

  always_comb begin
    xs = in_data.x >>> idx;
    ys = in_data.y >>> idx;
    nxt = in_data;
    if (!in_data.y[CW-1]) begin
      nxt.x = in_data.x + ys;
      nxt.y = in_data.y - xs;
      nxt.z = in_data.z + atan_q16(int'(idx));
    end else begin
      nxt.x = in_data.x - ys;
      nxt.y = in_data.y + xs;
      nxt.z = in_data.z - atan_q16(int'(idx));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

FILE: src/gtg_decide.sv
module gtg_decide
  import gtg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  cstage_t in_data,
  output logic    out_valid,
  output logic [14:0] linear_speed,
  output logic [14:0] angular_speed
);

  logic v1, v2;
  logic [43:0] prod;
  logic signed [ZW-1:0] err1;
  logic [43:0] prod_next;
  logic [16:0] dist2;
  logic signed [ZW-1:0] bearing;
  logic [ZW-1:0] aerr2;
  logic [31:0] lin_full;
  logic [14:0] lin_c;
  logic [14:0] ang_c;
  logic [14:0] lin_o, ang_o;

  always_comb begin
    prod_next = in_data.x[CW-1] ? '0 : 44'(in_data.x) * 44'(InvGainQ16);
    bearing = (in_data.z + ZW'(8)) >>> 4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
    if (en) begin
      prod <= prod_next;
      err1 <= bearing - ZW'(in_data.head);
      dist2 <= 17'((prod + 44'd8388608) >> 24);
      aerr2 <= err1[ZW-1] ? ZW'(-err1) : ZW'(err1);
    end
  end

  always_comb begin
    lin_full = 32'(dist2) * 32'(cfg.speed_gain);
    lin_c = (lin_full[31:12] > 20'(cfg.max_speed)) ? cfg.max_speed : lin_full[26:12];
    ang_c = (aerr2 > ZW'(OutMax)) ? OutMax : aerr2[14:0];
    lin_o = '0;
    ang_o = '0;
    if (dist2 > 17'(cfg.distance_threshold)) begin
      if (aerr2 > ZW'(cfg.angle_threshold)) begin
        ang_o = ang_c;
      end else begin
        lin_o = lin_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      linear_speed  <= lin_o;
      angular_speed <= ang_o;
    end
  end

endmodule
